FILE: hw/rtl/batch_preset_counter_macros.svh
// Assertion macros for the batch preset counter checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef BATCH_PRESET_COUNTER_MACROS_SVH
`define BATCH_PRESET_COUNTER_MACROS_SVH

// Checked only while out of reset.
`define BPC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpc check failed: %m");

// Checked during reset too.
`define BPC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bpc check failed: %m");

`endif

FILE: hw/rtl/bpc_pkg.sv
// Shared types and constants of the batch preset counter.
// No dependencies.
package bpc_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int THR_W           = 10;
  localparam int TARGET_W        = 10;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;

  // Operation codes; code 3 changes nothing.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_BASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_PER  = 3'd6;

  // Register reset values
  localparam logic [9:0]  RST_THRESH    = 10'd400;
  localparam logic [7:0]  RST_PRESCALE  = 8'd9;
  localparam logic [15:0] RST_HOLD      = 16'd30500;
  localparam logic [3:0]  RST_WINDOW    = 4'd6;
  localparam logic [11:0] RST_BEEP_BASE = 12'd400;
  localparam logic [9:0]  RST_BEEP_STEP = 10'd200;
  localparam logic [15:0] RST_ANIM_PER  = 16'd1000;

  // Animation frames: 0..11 cycle while armed, 11/12 alternate when idle.
  localparam logic [3:0] FRAME_LAST = 4'd11;
  localparam logic [3:0] FRAME_ALT  = 4'd12;

  typedef struct packed {
    logic [9:0]  thresh;
    logic [7:0]  prescale;
    logic [15:0] hold;
    logic [3:0]  window;
    logic [11:0] beep_base;
    logic [9:0]  beep_step;
    logic [15:0] anim_period;
  } bpc_cfg_t;

  typedef struct packed {
    logic [15:0] batch_count;
    logic [31:0] lifetime_count;
    logic        relay_on;
    logic        buzzer_on;
    logic        warn_led;
    logic        anim_active;
    logic [3:0]  anim_frame;
    logic        armed_out;
  } bpc_res_t;

endpackage

FILE: hw/rtl/bpc_cfg.sv
// Configuration register file of the batch preset counter.
// Depends on bpc_pkg.
module bpc_cfg import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output bpc_cfg_t             cfg
);

  bpc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh      <= RST_THRESH;
      cfg_r.prescale    <= RST_PRESCALE;
      cfg_r.hold        <= RST_HOLD;
      cfg_r.window      <= RST_WINDOW;
      cfg_r.beep_base   <= RST_BEEP_BASE;
      cfg_r.beep_step   <= RST_BEEP_STEP;
      cfg_r.anim_period <= RST_ANIM_PER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH:    cfg_r.thresh      <= cfg_wdata[9:0];
        REG_PRESCALE:  cfg_r.prescale    <= cfg_wdata[7:0];
        REG_HOLD:      cfg_r.hold        <= cfg_wdata;
        REG_WINDOW:    cfg_r.window      <= cfg_wdata[3:0];
        REG_BEEP_BASE: cfg_r.beep_base   <= cfg_wdata[11:0];
        REG_BEEP_STEP: cfg_r.beep_step   <= cfg_wdata[9:0];
        REG_ANIM_PER:  cfg_r.anim_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/bpc_core.sv
// Counter state and its per-item update for the batch preset counter.
// Depends on bpc_pkg; the update is applied when step is high.
module bpc_core import bpc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [1:0]             op,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [TARGET_W-1:0]    target_value,
  input  bpc_cfg_t               cfg,
  output bpc_res_t               res
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic        latch_r, latch_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic [15:0] batch_r, batch_nxt;
  logic [31:0] life_r, life_nxt;
  logic [9:0]  target_r, target_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [15:0] beep_r, beep_nxt;
  logic        buz_r, buz_nxt;
  logic        relay_r, relay_nxt;
  logic        led_r, led_nxt;
  logic        anim_en_r, anim_en_nxt;
  logic        show_r, show_nxt;
  logic [15:0] atick_r, atick_nxt;
  logic [3:0]  frame_r, frame_nxt;

  logic [CMP_W-1:0] samp_x, thr_x;
  assign samp_x = CMP_W'(sample);
  assign thr_x  = CMP_W'(cfg.thresh);

  always_comb begin
    logic        reached;
    logic        warn;
    logic [15:0] hold_inc;
    logic [15:0] atick_inc;
    logic [9:0]  diff;
    logic [13:0] prod;
    logic [14:0] period;

    latch_nxt = latch_r;   pc_nxt = pc_r;         batch_nxt = batch_r;
    life_nxt = life_r;     target_nxt = target_r; armed_nxt = armed_r;
    hold_nxt = hold_r;     beep_nxt = beep_r;     buz_nxt = buz_r;
    relay_nxt = relay_r;   led_nxt = led_r;       anim_en_nxt = anim_en_r;
    show_nxt = show_r;     atick_nxt = atick_r;   frame_nxt = frame_r;
    reached = 1'b0;  warn = 1'b0;
    hold_inc = hold_r + 16'd1;
    atick_inc = atick_r + 16'd1;
    diff = '0;  prod = '0;  period = '0;

    unique case (op)
      OP_TICK: begin
        if (!latch_r && samp_x > thr_x) begin
          if (pc_r == cfg.prescale) begin
            batch_nxt = batch_r + 16'd1;
            life_nxt  = life_r + 32'd1;
            pc_nxt    = '0;
          end else begin
            pc_nxt = pc_r + 8'd1;
          end
          latch_nxt = 1'b1;
        end

        reached = armed_r && (batch_nxt >= {6'b0, target_r});
        // batch > target - window, done unsigned without underflow
        warn = armed_r &&
               (({1'b0, batch_nxt} + 17'(cfg.window)) > {7'b0, target_r});
        // inside the window the remaining count is below 16
        diff   = target_r - batch_nxt[9:0];
        prod   = diff[3:0] * cfg.beep_step;
        period = {3'b0, cfg.beep_base} + {1'b0, prod};

        if (reached) begin
          buz_nxt   = 1'b1;
          relay_nxt = 1'b1;
          hold_nxt  = hold_inc;
          if (hold_inc > cfg.hold) begin
            hold_nxt  = '0;
            armed_nxt = 1'b0;
            frame_nxt = FRAME_LAST;
            buz_nxt   = 1'b0;
          end
        end else if (warn) begin
          led_nxt = 1'b1;
          if (beep_r < {1'b0, period}) begin
            beep_nxt = beep_r + 16'd1;
          end else begin
            buz_nxt  = ~buz_r;
            beep_nxt = '0;
          end
        end

        if (samp_x < thr_x) latch_nxt = 1'b0;

        if (anim_en_r) begin
          show_nxt  = 1'b1;
          atick_nxt = atick_inc;
          if (atick_inc == cfg.anim_period) begin
            atick_nxt = '0;
            if (armed_nxt) begin
              frame_nxt = (frame_nxt >= FRAME_LAST) ? 4'd0 : frame_nxt + 4'd1;
            end else begin
              frame_nxt = (frame_nxt == FRAME_LAST) ? FRAME_ALT : FRAME_LAST;
            end
          end
        end
      end
      OP_START: begin
        batch_nxt = '0;  pc_nxt = '0;  hold_nxt = '0;  beep_nxt = '0;
        atick_nxt = '0;  armed_nxt = 1'b0;  relay_nxt = 1'b0;
        buz_nxt = 1'b0;  led_nxt = 1'b0;  anim_en_nxt = 1'b0;
        show_nxt = 1'b0;
      end
      OP_LOAD: begin
        target_nxt  = target_value;
        armed_nxt   = 1'b1;
        anim_en_nxt = 1'b1;
        buz_nxt     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;  pc_r <= '0;  batch_r <= '0;  life_r <= '0;
      target_r <= '0;  armed_r <= 1'b0;  hold_r <= '0;  beep_r <= '0;
      buz_r <= 1'b0;  relay_r <= 1'b0;  led_r <= 1'b0;  anim_en_r <= 1'b0;
      show_r <= 1'b0;  atick_r <= '0;  frame_r <= '0;
    end else if (step) begin
      latch_r <= latch_nxt;  pc_r <= pc_nxt;  batch_r <= batch_nxt;
      life_r <= life_nxt;  target_r <= target_nxt;  armed_r <= armed_nxt;
      hold_r <= hold_nxt;  beep_r <= beep_nxt;  buz_r <= buz_nxt;
      relay_r <= relay_nxt;  led_r <= led_nxt;  anim_en_r <= anim_en_nxt;
      show_r <= show_nxt;  atick_r <= atick_nxt;  frame_r <= frame_nxt;
    end
  end

  always_comb begin
    res.batch_count    = batch_nxt;
    res.lifetime_count = life_nxt;
    res.relay_on       = relay_nxt;
    res.buzzer_on      = buz_nxt;
    res.warn_led       = led_nxt;
    res.anim_active    = show_nxt;
    res.anim_frame     = frame_nxt;
    res.armed_out      = armed_nxt;
  end

endmodule

FILE: hw/rtl/batch_preset_counter.sv
// Batch preset counter: one result per input item, in order.
// An item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle; the state update is one combinational pass in bpc_core.
// A stalled result holds the pipeline; the input register refills as the result drains.
// Reset (rst_n low, synchronous): empties both registers, clears the counter state,
// loads the configuration defaults.
module batch_preset_counter import bpc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_op,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [TARGET_W-1:0]    in_target_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_batch_count,
  output logic [31:0]            out_lifetime_count,
  output logic                   out_relay_on,
  output logic                   out_buzzer_on,
  output logic                   out_warn_led,
  output logic                   out_anim_active,
  output logic [3:0]             out_anim_frame,
  output logic                   out_armed_out,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic                   iv_r;
  logic [1:0]             op_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [TARGET_W-1:0]    target_r;
  logic                   ov_r;
  bpc_res_t               res_r;
  bpc_res_t               res;
  bpc_cfg_t               cfg;
  logic                   step;

  // the held item advances whenever the result register is free or draining
  assign step     = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_op;
      sample_r <= in_sample;
      target_r <= in_target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .op           (op_r),
    .sample       (sample_r),
    .target_value (target_r),
    .cfg          (cfg),
    .res          (res)
  );

  assign out_valid          = ov_r;
  assign out_batch_count    = res_r.batch_count;
  assign out_lifetime_count = res_r.lifetime_count;
  assign out_relay_on       = res_r.relay_on;
  assign out_buzzer_on      = res_r.buzzer_on;
  assign out_warn_led       = res_r.warn_led;
  assign out_anim_active    = res_r.anim_active;
  assign out_anim_frame     = res_r.anim_frame;
  assign out_armed_out      = res_r.armed_out;

endmodule

FILE: hw/rtl/bpc_checker.sv
// Port-level checks of the batch preset counter, bound to the top level.
// Depends on batch_preset_counter_macros.svh.
`include "batch_preset_counter_macros.svh"

module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_batch_count,
  input logic [31:0] out_lifetime_count,
  input logic        out_warn_led,
  input logic        out_anim_active,
  input logic [3:0]  out_anim_frame
);

  logic [31:0] prev_life_r;
  logic        have_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) prev_life_r <= out_lifetime_count;
  end

  `BPC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)
  `BPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_batch_count) && $stable(out_lifetime_count))
  `BPC_ASSERT(a_frame_range, out_valid |-> out_anim_frame <= 4'd12)
  `BPC_ASSERT(a_warn_anim, out_valid && out_warn_led |-> out_anim_active)
  `BPC_ASSERT(a_life_step, out_valid && have_prev_r |-> out_lifetime_count == prev_life_r || out_lifetime_count == prev_life_r + 32'd1)

endmodule

bind batch_preset_counter bpc_checker u_bpc_checker (.*);

FILE: tb/tb_batch_preset_counter.sv
// Self-checking testbench for batch_preset_counter: directed corner items, then randomized runs.
// Holds its own cycle model of the counter; depends on bpc_pkg and the batch_preset_counter RTL.
module tb_batch_preset_counter import bpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is accepted but leaves the state alone
  localparam logic [1:0] OP_NONE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_op = OP_TICK;
  logic [9:0]           in_sample = '0;
  logic [TARGET_W-1:0]  in_target_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [15:0]          out_batch_count;
  logic [31:0]          out_lifetime_count;
  logic                 out_relay_on;
  logic                 out_buzzer_on;
  logic                 out_warn_led;
  logic                 out_anim_active;
  logic [3:0]           out_anim_frame;
  logic                 out_armed_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_THRESH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  batch_preset_counter #(.SAMPLE_BITS(10)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_sample(in_sample),
    .in_target_value(in_target_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_batch_count(out_batch_count),
    .out_lifetime_count(out_lifetime_count), .out_relay_on(out_relay_on),
    .out_buzzer_on(out_buzzer_on), .out_warn_led(out_warn_led),
    .out_anim_active(out_anim_active), .out_anim_frame(out_anim_frame),
    .out_armed_out(out_armed_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Counter model state, mirrors the block after reset
  bpc_cfg_t    cur_cfg = '{thresh: RST_THRESH, prescale: RST_PRESCALE, hold: RST_HOLD,
                           window: RST_WINDOW, beep_base: RST_BEEP_BASE,
                           beep_step: RST_BEEP_STEP, anim_period: RST_ANIM_PER};
  logic        latch_q = 1'b0;
  logic [7:0]  pre_q = '0;
  logic [15:0] batch_q = '0;
  logic [31:0] life_q = '0;
  logic [9:0]  tgt_q = '0;
  logic        armed_q = 1'b0;
  logic [15:0] hold_q = '0;
  logic [15:0] beep_q = '0;
  logic        buzz_q = 1'b0;
  logic        relay_q = 1'b0;
  logic        led_q = 1'b0;
  logic        anim_en_q = 1'b0;
  logic        show_q = 1'b0;
  logic [15:0] atick_q = '0;
  logic [3:0]  frame_q = '0;

  bpc_res_t pending_status[$];
  int       errors = 0;
  int       n_items = 0;
  int       n_results = 0;
  int       n_settings = 0;
  bit       tx_idle_en = 1'b1;
  bit       rx_idle_en = 1'b1;
  int       rx_stall_left = 0;

  function automatic bpc_res_t advance_counter(input logic [1:0] op, input logic [9:0] sample,
                                               input logic [9:0] tgt);
    bpc_res_t    r;
    int          b;
    int          t;
    int          w;
    logic [31:0] remaining;
    logic [31:0] period;
    case (op)
      OP_TICK: begin
        if (!latch_q && sample > cur_cfg.thresh) begin
          if (pre_q == cur_cfg.prescale) begin
            batch_q = batch_q + 16'd1;
            life_q  = life_q + 32'd1;
            pre_q   = '0;
          end else begin
            pre_q = pre_q + 8'd1;
          end
          latch_q = 1'b1;
        end
        b = batch_q;
        t = tgt_q;
        w = cur_cfg.window;
        if (armed_q && {6'd0, batch_q} >= {12'd0, tgt_q}) begin
          buzz_q  = 1'b1;
          relay_q = 1'b1;
          hold_q  = hold_q + 16'd1;
          if (hold_q > cur_cfg.hold) begin
            hold_q  = '0;
            armed_q = 1'b0;
            frame_q = FRAME_LAST;
            buzz_q  = 1'b0;
          end
        end else if (armed_q && b > t - w) begin
          // signed window compare: target below window still counts as inside
          remaining = {22'd0, tgt_q} - {16'd0, batch_q};
          period = {20'd0, cur_cfg.beep_base} + remaining * {22'd0, cur_cfg.beep_step};
          led_q = 1'b1;
          if ({16'd0, beep_q} < period) begin
            beep_q = beep_q + 16'd1;
          end else begin
            buzz_q = ~buzz_q;
            beep_q = '0;
          end
        end
        if (sample < cur_cfg.thresh) latch_q = 1'b0;
        if (anim_en_q) begin
          show_q  = 1'b1;
          atick_q = atick_q + 16'd1;
          if (atick_q == cur_cfg.anim_period) begin
            atick_q = '0;
            if (armed_q) frame_q = (frame_q >= FRAME_LAST) ? 4'd0 : frame_q + 4'd1;
            else frame_q = (frame_q == FRAME_LAST) ? FRAME_ALT : FRAME_LAST;
          end
        end
      end
      OP_START: begin
        batch_q = '0; pre_q = '0; hold_q = '0; beep_q = '0; atick_q = '0;
        armed_q = 1'b0; relay_q = 1'b0; buzz_q = 1'b0; led_q = 1'b0;
        anim_en_q = 1'b0; show_q = 1'b0;
      end
      OP_LOAD: begin
        tgt_q = tgt;
        armed_q = 1'b1;
        anim_en_q = 1'b1;
        buzz_q = 1'b0;
      end
      default: ;
    endcase
    r.batch_count    = batch_q;
    r.lifetime_count = life_q;
    r.relay_on       = relay_q;
    r.buzzer_on      = buzz_q;
    r.warn_led       = led_q;
    r.anim_active    = show_q;
    r.anim_frame     = frame_q;
    r.armed_out      = armed_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Result side: random stall bursts hold out_ready low
  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_status
    bpc_res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_status.size() == 0) begin
        report_mismatch("result with nothing pending", out_batch_count, 32'd0);
      end else begin
        want = pending_status.pop_front();
        if (out_batch_count !== want.batch_count)
          report_mismatch("batch_count", out_batch_count, want.batch_count);
        if (out_lifetime_count !== want.lifetime_count)
          report_mismatch("lifetime_count", out_lifetime_count, want.lifetime_count);
        if (out_relay_on !== want.relay_on)
          report_mismatch("relay_on", out_relay_on, want.relay_on);
        if (out_buzzer_on !== want.buzzer_on)
          report_mismatch("buzzer_on", out_buzzer_on, want.buzzer_on);
        if (out_warn_led !== want.warn_led)
          report_mismatch("warn_led", out_warn_led, want.warn_led);
        if (out_anim_active !== want.anim_active)
          report_mismatch("anim_active", out_anim_active, want.anim_active);
        if (out_anim_frame !== want.anim_frame)
          report_mismatch("anim_frame", out_anim_frame, want.anim_frame);
        if (out_armed_out !== want.armed_out)
          report_mismatch("armed_out", out_armed_out, want.armed_out);
      end
    end
  end

  // One transfer on the input channel; valid stays up after it for back-to-back items
  task automatic send_item(input logic [1:0] op, input logic [9:0] sample,
                           input logic [9:0] tgt);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_sample       <= sample;
    in_target_value <= tgt;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(advance_counter(op, sample, tgt));
    n_items++;
  endtask

  // Stop sending and let every pending result drain, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_settings(input bpc_cfg_t c);
    put_reg(REG_THRESH,    CFG_W'(c.thresh));
    put_reg(REG_PRESCALE,  CFG_W'(c.prescale));
    put_reg(REG_HOLD,      c.hold);
    put_reg(REG_WINDOW,    CFG_W'(c.window));
    put_reg(REG_BEEP_BASE, CFG_W'(c.beep_base));
    put_reg(REG_BEEP_STEP, CFG_W'(c.beep_step));
    put_reg(REG_ANIM_PER,  c.anim_period);
    cfg_we <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  function automatic logic [9:0] pick_sample(input bit above);
    int th;
    th = cur_cfg.thresh;
    if (above) return (th == 1023) ? 10'd1023 : 10'($urandom_range(1023, th + 1));
    return (th == 0) ? 10'd0 : 10'($urandom_range(th - 1, 0));
  endfunction

  task automatic test_defaults_after_reset();
    send_item(OP_TICK, 10'd1023, 10'd0);
    send_item(OP_TICK, 10'd0, 10'd999);
    send_item(OP_TICK, 10'd400, 10'd512);   // level equal to threshold: no crossing, no release
    send_item(OP_TICK, 10'd401, 10'd0);
    send_item(OP_NONE, 10'd1023, 10'd999);
    send_item(OP_LOAD, 10'd0, 10'd0);       // target zero is reached at once
    send_item(OP_TICK, 10'd0, 10'd0);
    send_item(OP_START, 10'd512, 10'd512);
  endtask

  task automatic test_extreme_settings();
    wait_idle();
    // zero animation period: tick counter only matches after wrapping
    write_settings('{thresh: 10'd1023, prescale: 8'd255, hold: 16'hFFFF, window: 4'd0,
                     beep_base: 12'd4095, beep_step: 10'd1023, anim_period: 16'd0});
    send_item(OP_START, 10'd0, 10'd0);
    send_item(OP_LOAD, 10'd0, 10'd999);
    send_item(OP_TICK, 10'd1023, 10'd0);
    send_item(OP_TICK, 10'd1022, 10'd0);
    send_item(OP_TICK, 10'd0, 10'd0);
  endtask

  task automatic test_disarm_and_frames();
    wait_idle();
    write_settings('{thresh: 10'd0, prescale: 8'd0, hold: 16'd0, window: 4'd15,
                     beep_base: 12'd0, beep_step: 10'd0, anim_period: 16'd1});
    send_item(OP_START, 10'd0, 10'd0);
    send_item(OP_LOAD, 10'd0, 10'd1);
    send_item(OP_TICK, 10'd5, 10'd0);       // reach, zero hold -> disarm, frame alternates
    send_item(OP_TICK, 10'd0, 10'd0);
    send_item(OP_TICK, 10'd0, 10'd0);
    send_item(OP_LOAD, 10'd0, 10'd3);       // armed from the alternate frame -> wraps to 0
    send_item(OP_TICK, 10'd0, 10'd0);       // window wider than target: signed compare
    send_item(OP_TICK, 10'd0, 10'd0);
    send_item(OP_LOAD, 10'd0, 10'd999);
    send_item(OP_TICK, 10'd0, 10'd0);
  endtask

  task automatic run_phase(input int mode, input int count, input bit quiet);
    bpc_cfg_t   c;
    int         r;
    int         k;
    bit         hi;
    logic [9:0] t;
    wait_idle();
    c.thresh      = 10'($urandom_range(1022, 1));
    c.prescale    = 8'($urandom_range(3, 0));
    c.hold        = 16'($urandom_range(25, 0));
    c.window      = 4'($urandom_range(15, 0));
    c.beep_base   = 12'($urandom_range(12, 0));
    c.beep_step   = 10'($urandom_range(6, 0));
    c.anim_period = 16'($urandom_range(8, 1));
    if (mode == 1) begin
      c.prescale    = 8'($urandom_range(1, 0));
      c.hold        = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(80, 30));
      c.window      = 4'd15;
      c.beep_base   = $urandom_range(0, 1) ? 12'd4095 : 12'($urandom_range(30, 0));
      c.beep_step   = $urandom_range(0, 1) ? 10'd1023 : 10'($urandom_range(3, 0));
      c.anim_period = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(3, 1));
    end else if (mode == 2) begin
      c.thresh = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    end
    write_settings(c);
    if (quiet) begin
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
    end
    send_item(OP_START, 10'($urandom), 10'($urandom_range(999, 0)));
    send_item(OP_LOAD, 10'($urandom), 10'($urandom_range(12, 0)));
    hi = 1'b1;
    for (k = 0; k < count; k++) begin
      if (!quiet && k % 48 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(99, 0);
      if (r < 84) begin
        // mostly clean pulse train, sometimes a repeated level or a sample at threshold
        if ($urandom_range(0, 19) == 0) send_item(OP_TICK, cur_cfg.thresh, 10'($urandom));
        else send_item(OP_TICK, pick_sample(hi), 10'($urandom));
        if ($urandom_range(0, 9) != 0) hi = ~hi;
      end else if (r < 88) begin
        if ($urandom_range(0, 6) == 0) t = 10'($urandom_range(999, 0));
        else if (batch_q + 16'($urandom_range(12, 0)) > 16'd999) t = 10'd999;
        else t = 10'(batch_q + 16'($urandom_range(12, 0)));
        send_item(OP_LOAD, 10'($urandom), t);
      end else if (r < 90) begin
        send_item(OP_START, 10'($urandom), 10'($urandom_range(999, 0)));
      end else if (r < 93) begin
        send_item(OP_NONE, 10'($urandom), 10'($urandom_range(999, 0)));
      end else begin
        send_item(OP_TICK, 10'($urandom), 10'($urandom_range(999, 0)));
      end
    end
  endtask

  task automatic test_random_runs();
    run_phase(0, 190, 1'b0);
    run_phase(1, 190, 1'b0);
    run_phase(0, 190, 1'b0);
    run_phase(2, 190, 1'b0);
    run_phase(1, 190, 1'b0);
    run_phase(0, 190, 1'b0);
    run_phase(0, 190, 1'b1);
  endtask

  initial begin
    int w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_after_reset();
    test_extreme_settings();
    test_disarm_and_frames();
    test_random_runs();
    in_valid <= 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (w = 0; w < 2000 && pending_status.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_status.size() != 0)
      report_mismatch("results never arrived", pending_status.size(), 32'd0);
    $display("summary: %0d items sent, %0d results checked, %0d register sets written",
             n_items, n_results, n_settings);
    $display("summary: ticks, run starts, target loads, unused code, threshold and window edges");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results pending", pending_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
